// ===== src/akrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Analog key rapid trigger package
// Field widths, item kinds, state types and the table write word shared by
// the core and its index search unit.
// ----------------------------------------------------------------------------
package akrt_pkg;

   localparam int KIND_W   = 2;
   localparam int BUTTON_W = 4;
   localparam int ENTRY_W  = 6;
   localparam int VALUE_W  = 16;
   localparam int PIN_W    = 5;
   localparam int MASK_W   = 32;
   localparam int LEN_W    = 7;

   localparam logic [KIND_W-1:0] KIND_TABLE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PIN    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

   localparam logic [LEN_W-1:0] TABLE_LENGTH_RESET = 7'd64;

   typedef enum logic [2:0] {
      SRCH_IDLE,
      SRCH_TOP,
      SRCH_CHKTOP,
      SRCH_MID,
      SRCH_MIDCHK,
      SRCH_NBRLO,
      SRCH_NBRHI
   } search_state_type;

   typedef enum logic {
      CORE_IDLE,
      CORE_SEARCH
   } core_state_type;

   typedef struct packed {
      logic               en;
      logic [ENTRY_W-1:0] entry;
      logic [VALUE_W-1:0] value;
   } table_write_type;

endpackage

// ===== src/akrt_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Travel index search
// Holds the travel table memory and maps a reading to the nearest table
// index by end clamps and a bisection that reads one table entry at a time.
// ----------------------------------------------------------------------------
module akrt_search
   import akrt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  table_write_type      table_wr,
   input  logic [LEN_W-1:0]     table_length,
   input  logic                 search_start,
   input  logic [VALUE_W-1:0]   search_value,
   output logic                 search_done,
   output logic [IDX_W-1:0]     search_index
);

   localparam logic [8:0] DEPTH_L = 9'(TABLE_DEPTH);

   logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];

   search_state_type   state_ff, state_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [IDX_W-1:0]   mid_ff, mid_in;
   logic [VALUE_W-1:0] mv_ff, mv_in;
   logic [VALUE_W-1:0] v_ff, v_in;
   logic [VALUE_W-1:0] q_ff;
   logic               done_ff, done_in;
   logic [IDX_W-1:0]   index_ff, index_in;

   logic [IDX_W-1:0]   rd_addr;
   logic [8:0]         len_ext;
   logic [8:0]         used_len;
   logic [IDX_W-1:0]   top;
   logic [IDX_W:0]     mid_sum;
   logic [IDX_W-1:0]   mid_calc;
   logic [IDX_W-1:0]   mid_dn;
   logic [IDX_W-1:0]   mid_up;
   logic [VALUE_W-1:0] diff_a;
   logic [VALUE_W-1:0] diff_b;

   always_comb begin
      len_ext = 9'(table_length);
      if (len_ext < 9'd2) begin
         used_len = 9'd2;
      end else if (len_ext > DEPTH_L) begin
         used_len = DEPTH_L;
      end else begin
         used_len = len_ext;
      end
      top = IDX_W'(used_len - 9'd1);
   end

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[IDX_W:1];
   assign mid_dn   = mid_ff - IDX_W'(1);
   assign mid_up   = mid_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (table_wr.en) begin
         table_mem[IDX_W'(table_wr.entry)] <= table_wr.value;
      end
      q_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SRCH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      mv_ff    <= mv_in;
      v_ff     <= v_in;
      index_ff <= index_in;
   end

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      mv_in    = mv_ff;
      v_in     = v_ff;
      done_in  = 1'b0;
      index_in = index_ff;
      rd_addr  = '0;
      diff_a   = '0;
      diff_b   = '0;
      unique case (state_ff)
         SRCH_IDLE: begin
            if (search_start) begin
               v_in     = search_value;
               state_in = SRCH_TOP;
            end
         end
         SRCH_TOP: begin
            rd_addr = top;
            if (v_ff <= q_ff) begin
               index_in = '0;
               done_in  = 1'b1;
               state_in = SRCH_IDLE;
            end else begin
               state_in = SRCH_CHKTOP;
            end
         end
         SRCH_CHKTOP: begin
            if (v_ff >= q_ff) begin
               index_in = top;
               done_in  = 1'b1;
               state_in = SRCH_IDLE;
            end else begin
               lo_in    = '0;
               hi_in    = top;
               state_in = SRCH_MID;
            end
         end
         SRCH_MID: begin
            rd_addr  = mid_calc;
            mid_in   = mid_calc;
            state_in = SRCH_MIDCHK;
         end
         SRCH_MIDCHK: begin
            mv_in = q_ff;
            if (v_ff == q_ff) begin
               index_in = mid_ff;
               done_in  = 1'b1;
               state_in = SRCH_IDLE;
            end else if (v_ff < q_ff) begin
               rd_addr = mid_dn;
               if (mid_ff == '0) begin
                  index_in = '0;
                  done_in  = 1'b1;
                  state_in = SRCH_IDLE;
               end else begin
                  state_in = SRCH_NBRLO;
               end
            end else begin
               rd_addr = mid_up;
               if (mid_ff >= top) begin
                  index_in = top;
                  done_in  = 1'b1;
                  state_in = SRCH_IDLE;
               end else begin
                  state_in = SRCH_NBRHI;
               end
            end
         end
         SRCH_NBRLO: begin
            diff_a = v_ff - q_ff;
            diff_b = mv_ff - v_ff;
            if (v_ff > q_ff) begin
               index_in = (diff_a < diff_b) ? mid_dn : mid_ff;
               done_in  = 1'b1;
               state_in = SRCH_IDLE;
            end else begin
               hi_in = mid_dn;
               if (lo_ff <= mid_dn) begin
                  state_in = SRCH_MID;
               end else begin
                  index_in = lo_ff;
                  done_in  = 1'b1;
                  state_in = SRCH_IDLE;
               end
            end
         end
         SRCH_NBRHI: begin
            diff_a = q_ff - v_ff;
            diff_b = v_ff - mv_ff;
            if (v_ff < q_ff) begin
               index_in = (diff_a < diff_b) ? mid_up : mid_ff;
               done_in  = 1'b1;
               state_in = SRCH_IDLE;
            end else begin
               lo_in = mid_up;
               if (mid_up <= hi_ff) begin
                  state_in = SRCH_MID;
               end else begin
                  index_in = mid_up;
                  done_in  = 1'b1;
                  state_in = SRCH_IDLE;
               end
            end
         end
         default: begin
            state_in = SRCH_IDLE;
         end
      endcase
   end

   assign search_done  = done_ff;
   assign search_index = index_ff;

endmodule

// ===== src/analog_key_rapid_trigger_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Analog key rapid trigger core
// Table and pin loads are written at the accepting edge. A valid sample with
// a nonzero reading keeps busy high through an end check at each table end,
// bisection steps on the single table read port and a final update. A result
// word is valid for the cycle after the edge at which its item finishes, which
// is the accepting edge when no search runs; the receiver cannot stall. Reset
// is synchronous and clears all but the table, result mask and data regs.
// ----------------------------------------------------------------------------
module analog_key_rapid_trigger_core
   import akrt_pkg::*;
#(
   parameter int NUM_BUTTONS = 16,
   parameter int TABLE_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [BUTTON_W-1:0] req_button,
   input  logic [ENTRY_W-1:0]  req_entry,
   input  logic [VALUE_W-1:0]  req_table_value,
   input  logic [PIN_W-1:0]    req_pin,
   input  logic [VALUE_W-1:0]  req_sample,
   input  logic                req_last_of_scan,
   output logic                rsp_valid,
   output logic [MASK_W-1:0]   rsp_pin_mask,
   input  logic                csr_write_enable,
   input  logic [LEN_W-1:0]    csr_write_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   core_state_type     state_ff, state_in;
   logic [LEN_W-1:0]   len_ff;
   logic [PIN_W-1:0]   pin_ff [NUM_BUTTONS];
   logic [PIN_W-1:0]   pin_in [NUM_BUTTONS];
   logic [IDX_W-1:0]   last_idx_ff [NUM_BUTTONS];
   logic [IDX_W-1:0]   last_idx_in [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] pressed_ff, pressed_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic               changed_ff, changed_in;
   logic [BTN_W-1:0]   btn_ff, btn_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;

   logic               accept;
   logic               button_ok;
   logic               entry_ok;
   logic [BTN_W-1:0]   req_btn;
   table_write_type    table_wr;
   logic               search_start;
   logic               search_done;
   logic [IDX_W-1:0]   search_index;
   logic [MASK_W-1:0]  pin_bit;
   logic               press;
   logic               release_key;
   logic               changed_new;
   logic [MASK_W-1:0]  mask_new;

   assign accept    = start && (state_ff == CORE_IDLE);
   assign button_ok = 32'(req_button) < 32'(NUM_BUTTONS);
   assign entry_ok  = 32'(req_entry) < 32'(TABLE_DEPTH);
   assign req_btn   = BTN_W'(req_button);

   assign table_wr.en    = accept && (req_kind == KIND_TABLE) && entry_ok;
   assign table_wr.entry = req_entry;
   assign table_wr.value = req_table_value;

   assign search_start = accept && (req_kind == KIND_SAMPLE) && button_ok
                         && (req_sample != '0);

   akrt_search #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_search (
      .clock        (clock),
      .reset        (reset),
      .table_wr     (table_wr),
      .table_length (len_ff),
      .search_start (search_start),
      .search_value (req_sample),
      .search_done  (search_done),
      .search_index (search_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CORE_IDLE;
         len_ff       <= TABLE_LENGTH_RESET;
         pressed_ff   <= '0;
         mask_ff      <= '0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            pin_ff[i]      <= '0;
            last_idx_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) begin
            len_ff <= csr_write_data;
         end
         pressed_ff   <= pressed_in;
         mask_ff      <= mask_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            pin_ff[i]      <= pin_in[i];
            last_idx_ff[i] <= last_idx_in[i];
         end
      end
      btn_ff      <= btn_in;
      last_ff     <= last_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   always_comb begin
      pin_bit     = MASK_W'(1) << pin_ff[btn_ff];
      press       = !pressed_ff[btn_ff] && (search_index < last_idx_ff[btn_ff]);
      release_key = pressed_ff[btn_ff] && (search_index > last_idx_ff[btn_ff]);
      if (press) begin
         mask_new = mask_ff | pin_bit;
      end else if (release_key) begin
         mask_new = mask_ff & ~pin_bit;
      end else begin
         mask_new = mask_ff;
      end
      changed_new = changed_ff || press || release_key;
   end

   always_comb begin
      state_in     = state_ff;
      pin_in       = pin_ff;
      last_idx_in  = last_idx_ff;
      pressed_in   = pressed_ff;
      mask_in      = mask_ff;
      changed_in   = changed_ff;
      btn_in       = btn_ff;
      last_in      = last_ff;
      rsp_valid_in = 1'b0;
      rsp_mask_in  = rsp_mask_ff;
      unique case (state_ff)
         CORE_IDLE: begin
            if (accept && (req_kind == KIND_PIN) && button_ok) begin
               pin_in[req_btn] = req_pin;
            end
            if (search_start) begin
               btn_in   = req_btn;
               last_in  = req_last_of_scan;
               state_in = CORE_SEARCH;
            end else if (accept && (req_kind == KIND_SAMPLE) && req_last_of_scan
                         && changed_ff) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = mask_ff;
               changed_in   = 1'b0;
            end
         end
         CORE_SEARCH: begin
            if (search_done) begin
               pressed_in[btn_ff]  = press || (pressed_ff[btn_ff] && !release_key);
               last_idx_in[btn_ff] = search_index;
               mask_in             = mask_new;
               if (last_ff && changed_new) begin
                  rsp_valid_in = 1'b1;
                  rsp_mask_in  = mask_new;
                  changed_in   = 1'b0;
               end else begin
                  changed_in = changed_new;
               end
               state_in = CORE_IDLE;
            end
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase
   end

   assign busy         = (state_ff != CORE_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pin_mask = rsp_mask_ff;

endmodule
